// ----- src/bld_pkg.sv -----
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types, constants and functions of the binary log deframer.
// ----------------------------------------------------------------------------
package bld_pkg;

    localparam int CNT_W            = 17;
    localparam int CRC_BYTES        = 4;
    localparam int LANE_W           = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;
    localparam int DEF_LONG_HDR     = 28;
    localparam int DEF_SHORT_HDR    = 12;
    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd68;
    localparam logic [7:0] SYNC_LONG_RST   = 8'd18;
    localparam logic [7:0] SYNC_SHORT_RST  = 8'd19;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_SYNC_LONG   = 2'd2,
        REG_SYNC_SHORT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC1  = 3'd1,
        PH_SYNC2  = 3'd2,
        PH_HEADER = 3'd3,
        PH_BODY   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        OP_CRC_FIRST   = 3'd0,
        OP_CRC         = 3'd1,
        OP_FRAME_START = 3'd2,
        OP_HEADER      = 3'd3,
        OP_PAYLOAD     = 3'd4,
        OP_CRC_RX      = 3'd5,
        OP_CRC_LAST    = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        SEL_NONE    = 3'd0,
        SEL_ID      = 3'd1,
        SEL_LEN     = 3'd2,
        SEL_LEN_ALL = 3'd3,
        SEL_WEEK    = 3'd4,
        SEL_MS      = 3'd5
    } t_hdr_sel;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_CRC_GOOD = 2'd1,
        KIND_CRC_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] sync_long;
        logic [7:0] sync_short;
    } t_cfg;

    typedef struct packed {
        t_hdr_sel          sel;
        logic [LANE_W-1:0] lane;
    } t_hdr_field;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        t_hdr_field        field;
        logic              is_long;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        is_long_header;
        logic [15:0] msg_id;
        logic [15:0] msg_len;
        logic [15:0] week_num;
        logic [31:0] week_ms;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [7:0]  x;
        logic [31:0] w;
        x = crc[7:0] ^ b;
        w = {24'd0, x};
        for (int k = 0; k < 8; k++) begin
            w = w[0] ? ((w >> 1) ^ CRC_POLY) : (w >> 1);
        end
        return {8'd0, crc[31:8]} ^ w;
    endfunction

    function automatic t_hdr_field hdr_field(input logic is_long, input logic [CNT_W-1:0] off);
        t_hdr_field f;
        f.sel  = SEL_NONE;
        f.lane = '0;
        if (is_long) begin
            unique case (off)
                17'd4:  begin f.sel = SEL_ID;   f.lane = 2'd0; end
                17'd5:  begin f.sel = SEL_ID;   f.lane = 2'd1; end
                17'd8:  begin f.sel = SEL_LEN;  f.lane = 2'd0; end
                17'd9:  begin f.sel = SEL_LEN;  f.lane = 2'd1; end
                17'd14: begin f.sel = SEL_WEEK; f.lane = 2'd0; end
                17'd15: begin f.sel = SEL_WEEK; f.lane = 2'd1; end
                17'd16: begin f.sel = SEL_MS;   f.lane = 2'd0; end
                17'd17: begin f.sel = SEL_MS;   f.lane = 2'd1; end
                17'd18: begin f.sel = SEL_MS;   f.lane = 2'd2; end
                17'd19: begin f.sel = SEL_MS;   f.lane = 2'd3; end
                default: f.sel = SEL_NONE;
            endcase
        end else begin
            unique case (off)
                17'd3:  begin f.sel = SEL_LEN_ALL; f.lane = 2'd0; end
                17'd4:  begin f.sel = SEL_ID;      f.lane = 2'd0; end
                17'd5:  begin f.sel = SEL_ID;      f.lane = 2'd1; end
                17'd6:  begin f.sel = SEL_WEEK;    f.lane = 2'd0; end
                17'd7:  begin f.sel = SEL_WEEK;    f.lane = 2'd1; end
                17'd8:  begin f.sel = SEL_MS;      f.lane = 2'd0; end
                17'd9:  begin f.sel = SEL_MS;      f.lane = 2'd1; end
                17'd10: begin f.sel = SEL_MS;      f.lane = 2'd2; end
                17'd11: begin f.sel = SEL_MS;      f.lane = 2'd3; end
                default: f.sel = SEL_NONE;
            endcase
        end
        return f;
    endfunction

    function automatic logic [15:0] put16(input logic [15:0] v, input logic [7:0] b,
                                          input logic lane);
        return lane ? {b, v[7:0]} : {v[15:8], b};
    endfunction

    function automatic logic [31:0] put32(input logic [31:0] v, input logic [7:0] b,
                                          input logic [LANE_W-1:0] lane);
        logic [31:0] r;
        r = v;
        unique case (lane)
            2'd0: r[7:0]   = b;
            2'd1: r[15:8]  = b;
            2'd2: r[23:16] = b;
            2'd3: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bld_front.sv -----
// ----------------------------------------------------------------------------
// bld_front
// Sync hunt and frame framing: classifies each byte into a back-end operation.
// ----------------------------------------------------------------------------
module bld_front #(
    parameter int LONG_HEADER_BYTES  = bld_pkg::DEF_LONG_HDR,
    parameter int SHORT_HEADER_BYTES = bld_pkg::DEF_SHORT_HDR
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  bld_pkg::t_cfg  i_cfg,
    input  logic           i_room,
    output logic           o_push,
    output bld_pkg::t_item o_item
);
    import bld_pkg::*;

    localparam logic [CNT_W-1:0] HDR_LONG  = CNT_W'(LONG_HEADER_BYTES);
    localparam logic [CNT_W-1:0] HDR_SHORT = CNT_W'(SHORT_HEADER_BYTES);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pay_end, n_pay_end;
    logic             r_long, n_long;
    logic [15:0]      r_len, n_len;

    logic             w_fire;
    logic             w_hit_first, w_hit_second, w_hit_long, w_hit_short;
    logic [CNT_W-1:0] w_hdr, w_cnt_inc, w_frame_end;
    logic             w_in_pay;
    t_hdr_field       w_field;

    assign o_ready      = i_room;
    assign w_fire       = i_valid && i_room;
    assign w_hit_first  = (i_byte == i_cfg.sync_first);
    assign w_hit_second = (i_byte == i_cfg.sync_second);
    assign w_hit_long   = (i_byte == i_cfg.sync_long);
    assign w_hit_short  = (i_byte == i_cfg.sync_short);
    assign w_hdr        = r_long ? HDR_LONG : HDR_SHORT;
    assign w_cnt_inc    = r_count + 1'b1;
    assign w_frame_end  = r_pay_end + CNT_W'(CRC_BYTES);
    assign w_in_pay     = (r_count < r_pay_end);
    assign w_field      = hdr_field(r_long, r_count);

    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            unique case (r_phase)
                PH_HUNT:   n_phase = w_hit_first ? PH_SYNC1 : PH_HUNT;
                PH_SYNC1: begin
                    if (w_hit_second) n_phase = PH_SYNC2;
                    else              n_phase = w_hit_first ? PH_SYNC1 : PH_HUNT;
                end
                PH_SYNC2: begin
                    if (w_hit_long || w_hit_short) n_phase = PH_HEADER;
                    else                           n_phase = w_hit_first ? PH_SYNC1 : PH_HUNT;
                end
                PH_HEADER: n_phase = (w_cnt_inc >= w_hdr) ? PH_BODY : PH_HEADER;
                PH_BODY: begin
                    if (!w_in_pay && (w_cnt_inc >= w_frame_end)) n_phase = PH_HUNT;
                end
                default:   n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_count          = r_count;
        n_pay_end        = r_pay_end;
        n_long           = r_long;
        n_len            = r_len;
        o_push           = 1'b0;
        o_item.op        = OP_CRC;
        o_item.data      = i_byte;
        o_item.field     = w_field;
        o_item.is_long   = r_long;
        if (w_fire) begin
            priority case (1'b1)
                (r_phase == PH_SYNC1) && w_hit_second: begin
                    n_count   = CNT_W'(2);
                    o_push    = 1'b1;
                    o_item.op = OP_CRC;
                end
                (r_phase == PH_SYNC2) && (w_hit_long || w_hit_short): begin
                    n_count        = CNT_W'(3);
                    n_long         = w_hit_long;
                    n_len          = '0;
                    o_push         = 1'b1;
                    o_item.op      = OP_FRAME_START;
                    o_item.is_long = w_hit_long;
                end
                (r_phase == PH_HEADER): begin
                    n_count   = w_cnt_inc;
                    if (w_field.sel == SEL_LEN)     n_len = put16(r_len, i_byte, w_field.lane[0]);
                    if (w_field.sel == SEL_LEN_ALL) n_len = {8'd0, i_byte};
                    n_pay_end = w_hdr + {1'b0, n_len};
                    o_push    = 1'b1;
                    o_item.op = OP_HEADER;
                end
                (r_phase == PH_BODY): begin
                    o_push = 1'b1;
                    if (w_in_pay) begin
                        n_count   = w_cnt_inc;
                        o_item.op = OP_PAYLOAD;
                    end else begin
                        o_item.field.sel  = SEL_NONE;
                        o_item.field.lane = LANE_W'(r_count - r_pay_end);
                        if (w_cnt_inc >= w_frame_end) begin
                            n_count   = '0;
                            o_item.op = OP_CRC_LAST;
                        end else begin
                            n_count   = w_cnt_inc;
                            o_item.op = OP_CRC_RX;
                        end
                    end
                end
                default: begin
                    n_count   = w_hit_first ? CNT_W'(1) : '0;
                    o_push    = w_hit_first;
                    o_item.op = OP_CRC_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_pay_end <= '0;
            r_long    <= 1'b0;
            r_len     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_pay_end <= n_pay_end;
            r_long    <= n_long;
            r_len     <= n_len;
        end
    end

endmodule

// ----- src/bld_queue.sv -----
// ----------------------------------------------------------------------------
// bld_queue
// Small first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module bld_queue #(
    parameter int DEPTH = bld_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bld_pkg::t_item i_item,
    output logic           o_room,
    input  logic           i_pop,
    output logic           o_valid,
    output bld_pkg::t_item o_item
);
    import bld_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_Q-1:0] r_fill, n_fill;
    logic             w_push, w_pop;

    assign o_room  = (r_fill != CNT_Q'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (w_push) n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        if (w_pop)  n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        if (w_push && !w_pop)      n_fill = r_fill + 1'b1;
        else if (!w_push && w_pop) n_fill = r_fill - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ----- src/bld_back.sv -----
// ----------------------------------------------------------------------------
// bld_back
// CRC engine and header capture; drives the registered result stage.
// ----------------------------------------------------------------------------
module bld_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bld_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bld_pkg::t_result o_out
);
    import bld_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic [31:0] r_crc_rx, n_crc_rx;
    logic        r_long, n_long;
    logic [15:0] r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_week, n_week;
    logic [31:0] r_ms, n_ms;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        w_emits, w_slot;
    logic [31:0] w_crc_next, w_rx_next;

    assign w_emits    = (i_item.op == OP_PAYLOAD) || (i_item.op == OP_CRC_LAST);
    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_pop      = i_valid && (!w_emits || w_slot);
    assign w_crc_next = crc_byte(r_crc, i_item.data);
    assign w_rx_next  = put32(r_crc_rx, i_item.data, i_item.field.lane);

    always_comb begin
        n_crc       = r_crc;
        n_crc_rx    = r_crc_rx;
        n_long      = r_long;
        n_id        = r_id;
        n_len       = r_len;
        n_week      = r_week;
        n_ms        = r_ms;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (o_pop) begin
            unique case (i_item.op)
                OP_CRC_FIRST: begin
                    n_crc    = crc_byte(32'd0, i_item.data);
                    n_crc_rx = '0;
                end
                OP_CRC: n_crc = w_crc_next;
                OP_FRAME_START: begin
                    n_crc  = w_crc_next;
                    n_long = i_item.is_long;
                    n_id   = '0;
                    n_len  = '0;
                    n_week = '0;
                    n_ms   = '0;
                end
                OP_HEADER: begin
                    n_crc = w_crc_next;
                    unique case (i_item.field.sel)
                        SEL_ID:      n_id   = put16(r_id, i_item.data, i_item.field.lane[0]);
                        SEL_LEN:     n_len  = put16(r_len, i_item.data, i_item.field.lane[0]);
                        SEL_LEN_ALL: n_len  = {8'd0, i_item.data};
                        SEL_WEEK:    n_week = put16(r_week, i_item.data, i_item.field.lane[0]);
                        SEL_MS:      n_ms   = put32(r_ms, i_item.data, i_item.field.lane);
                        default:     n_id   = r_id;
                    endcase
                end
                OP_PAYLOAD: begin
                    n_crc              = w_crc_next;
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_PAYLOAD;
                    n_out.payload_byte = i_item.data;
                end
                OP_CRC_RX: n_crc_rx = w_rx_next;
                OP_CRC_LAST: begin
                    n_crc              = '0;
                    n_crc_rx           = '0;
                    n_out_valid        = 1'b1;
                    n_out.kind         = (w_rx_next == r_crc) ? KIND_CRC_GOOD : KIND_CRC_BAD;
                    n_out.payload_byte = '0;
                end
                default: n_crc = r_crc;
            endcase
            if (w_emits) begin
                n_out.is_long_header = r_long;
                n_out.msg_id         = r_id;
                n_out.msg_len        = r_len;
                n_out.week_num       = r_week;
                n_out.week_ms        = r_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_crc_rx    <= '0;
            r_long      <= 1'b0;
            r_id        <= '0;
            r_len       <= '0;
            r_week      <= '0;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_crc_rx    <= n_crc_rx;
            r_long      <= n_long;
            r_id        <= n_id;
            r_len       <= n_len;
            r_week      <= n_week;
            r_ms        <= n_ms;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/binary_log_deframer_crc32.sv -----
// ----------------------------------------------------------------------------
// binary_log_deframer_crc32
// Deframes a binary log byte stream, captures header fields, checks CRC-32.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output accepts results and the queue
// has room. Path: a byte taken at the input is written into the queue, and the
// back end then moves its result into the output register. Output stalls back
// up through the queue to the input.
// Reset: synchronous, active low; sync registers return to 170, 68, 18, 19.
// ----------------------------------------------------------------------------
module binary_log_deframer_crc32 #(
    parameter int LONG_HEADER_BYTES  = bld_pkg::DEF_LONG_HDR,
    parameter int SHORT_HEADER_BYTES = bld_pkg::DEF_SHORT_HDR,
    parameter int QUEUE_DEPTH        = bld_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] stream_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] payload_byte, [8] is_long_header, [24:9] msg_id,
    // [40:25] msg_len, [56:41] week_num, [88:57] week_ms
    output logic [95:0]                      m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,   // [1:0] result_kind
    input  logic                             i_cfg_we,
    input  logic [bld_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bld_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bld_pkg::*;

    t_cfg    r_cfg;
    logic    w_room, w_push, w_q_valid, w_pop;
    t_item   w_push_item, w_q_item;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.sync_long   <= SYNC_LONG_RST;
            r_cfg.sync_short  <= SYNC_SHORT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                REG_SYNC_LONG:   r_cfg.sync_long   <= i_cfg_data;
                REG_SYNC_SHORT:  r_cfg.sync_short  <= i_cfg_data;
            endcase
        end
    end

    bld_front #(
        .LONG_HEADER_BYTES  (LONG_HEADER_BYTES),
        .SHORT_HEADER_BYTES (SHORT_HEADER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .i_room  (w_room),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    bld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    bld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tuser = w_out.kind;
    assign m_axis_tdata = {7'd0, w_out.week_ms, w_out.week_num, w_out.msg_len,
                           w_out.msg_id, w_out.is_long_header, w_out.payload_byte};

endmodule
